>>> rtl/stall_detect_and_restart_core_macros.svh
// Assertion helpers shared by the stall guard modules.
`ifndef STALL_DETECT_AND_RESTART_CORE_MACROS_SVH
`define STALL_DETECT_AND_RESTART_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stall guard check failed");

// The consequent must hold in the cycle after the antecedent.
`define SDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stall guard check failed");

`endif

>>> rtl/sdr_pkg.sv
package sdr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_OPTION_FLAGS  = 3'd0;
  localparam logic [2:0] CFG_CONFIRM_TICKS = 3'd1;
  localparam logic [2:0] CFG_RELEASE_TICKS = 3'd2;
  localparam logic [2:0] CFG_RESTART_WAIT  = 3'd3;
  localparam logic [2:0] CFG_RESTART_LIMIT = 3'd4;
  localparam logic [2:0] CFG_RELEASE_SPEED = 3'd5;
  localparam logic [2:0] CFG_ERROR_BAND    = 3'd6;

  localparam int unsigned CfgDataWidth = 16;

  // Option flag bit positions.
  localparam int unsigned OPT_ENABLE      = 0;
  localparam int unsigned OPT_COUNT_EVENT = 1;
  localparam int unsigned OPT_AUTO_RESTART = 2;
  localparam int unsigned OPT_LATCH_FAULT = 3;
  localparam int unsigned OPT_EXH_FAULT   = 4;
  localparam int unsigned OPT_CLEAR_FAULT = 5;

  // Tick kinds.
  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_POLL   = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  // Drive states.
  localparam logic [1:0] DRIVE_RUNNING = 2'd0;
  localparam logic [1:0] DRIVE_STOPPED = 2'd1;

  localparam logic [15:0] TICK_MAX = 16'hFFFF;

  typedef struct packed {
    logic [5:0]  option_flags;
    logic [15:0] confirm_len;
    logic [15:0] release_len;
    logic [15:0] restart_wait_ticks;
    logic [7:0]  restart_limit;
    logic [14:0] release_speed;
    logic [14:0] error_band;
  } sdr_cfg_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         drive_state;
    logic               velocity_mode;
    logic               stall_candidate;
    logic signed [15:0] shaft_speed;
    logic signed [15:0] loop_err;
    logic               target_present;
  } sdr_in_t;

  typedef struct packed {
    logic        stalled;
    logic        restart_stop;
    logic        fault_stop;
    logic        exhausted_fault;
    logic        clear_faults;
    logic        run_request_valid;
    logic        run_request;
    logic [7:0]  attempts;
    logic [31:0] event_total;
  } sdr_out_t;

  // Saturating tick counter increment.
  function automatic logic [15:0] sdr_bump(input logic [15:0] v);
    return (v == TICK_MAX) ? TICK_MAX : v + 16'd1;
  endfunction

  // Magnitude of a signed 16-bit value; the most negative value maps to 32768.
  function automatic logic [15:0] sdr_mag(input logic [15:0] v);
    return v[15] ? (~v + 16'd1) : v;
  endfunction

endpackage

>>> rtl/sdr_cfg_regs.sv
module sdr_cfg_regs
  import sdr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output sdr_cfg_t                cfg_o
);

  sdr_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OPTION_FLAGS:  cfg_d.option_flags       = cfg_data_i[5:0];
        CFG_CONFIRM_TICKS: cfg_d.confirm_len        = cfg_data_i;
        CFG_RELEASE_TICKS: cfg_d.release_len        = cfg_data_i;
        CFG_RESTART_WAIT:  cfg_d.restart_wait_ticks = cfg_data_i;
        CFG_RESTART_LIMIT: cfg_d.restart_limit      = cfg_data_i[7:0];
        CFG_RELEASE_SPEED: cfg_d.release_speed      = cfg_data_i[14:0];
        CFG_ERROR_BAND:    cfg_d.error_band         = cfg_data_i[14:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.option_flags       <= '0;
      cfg_q.confirm_len        <= 16'd1;
      cfg_q.release_len        <= 16'd1;
      cfg_q.restart_wait_ticks <= 16'd1;
      cfg_q.restart_limit      <= '0;
      cfg_q.release_speed      <= '0;
      cfg_q.error_band         <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sdr_guard.sv
`include "stall_detect_and_restart_core_macros.svh"

module sdr_guard
  import sdr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  sdr_cfg_t cfg_i,
  input  sdr_in_t  item_i,
  output sdr_out_t result_o
);

  logic        stall_flag_q, stall_flag_d;
  logic [15:0] cand_cnt_q, cand_cnt_d;
  logic [15:0] rel_cnt_q, rel_cnt_d;
  logic [15:0] wait_cnt_q, wait_cnt_d;
  logic [7:0]  attempt_q, attempt_d;
  logic        pending_q, pending_d;
  logic [31:0] event_q, event_d;

  logic [15:0] spd_mag, err_mag;
  logic [15:0] cand_inc, rel_inc, wait_inc;
  logic        active, recovered;
  sdr_out_t    res;

  assign spd_mag   = sdr_mag(item_i.shaft_speed);
  assign err_mag   = sdr_mag(item_i.loop_err);
  assign cand_inc  = sdr_bump(cand_cnt_q);
  assign rel_inc   = sdr_bump(rel_cnt_q);
  assign wait_inc  = sdr_bump(wait_cnt_q);
  assign active    = cfg_i.option_flags[OPT_ENABLE] && (item_i.drive_state == DRIVE_RUNNING)
                     && item_i.velocity_mode;
  assign recovered = (spd_mag >= {1'b0, cfg_i.release_speed})
                     || (err_mag <= {1'b0, cfg_i.error_band});

  always_comb begin
    stall_flag_d = stall_flag_q;
    cand_cnt_d   = cand_cnt_q;
    rel_cnt_d    = rel_cnt_q;
    wait_cnt_d   = wait_cnt_q;
    attempt_d    = attempt_q;
    pending_d    = pending_q;
    event_d      = event_q;
    res          = '0;

    case (item_i.kind)
      KIND_UPDATE: begin
        if (!active) begin
          stall_flag_d = 1'b0;
          cand_cnt_d   = '0;
          rel_cnt_d    = '0;
        end else if (item_i.stall_candidate) begin
          rel_cnt_d = '0;
          if (!stall_flag_q) begin
            cand_cnt_d = cand_inc;
            if (cand_inc >= cfg_i.confirm_len) begin
              stall_flag_d = 1'b1;
              cand_cnt_d   = cfg_i.confirm_len;
              if (cfg_i.option_flags[OPT_COUNT_EVENT]) begin
                event_d = event_q + 32'd1;
              end
              if (cfg_i.option_flags[OPT_AUTO_RESTART]) begin
                if (attempt_q < cfg_i.restart_limit) begin
                  attempt_d        = attempt_q + 8'd1;
                  pending_d        = 1'b1;
                  wait_cnt_d       = '0;
                  res.restart_stop = 1'b1;
                  cand_cnt_d       = '0;
                end else begin
                  res.exhausted_fault = cfg_i.option_flags[OPT_EXH_FAULT];
                  res.fault_stop      = 1'b1;
                end
              end else if (cfg_i.option_flags[OPT_LATCH_FAULT]) begin
                res.fault_stop = 1'b1;
              end
            end
          end
        end else begin
          cand_cnt_d = '0;
          if (stall_flag_q) begin
            if (recovered) begin
              rel_cnt_d = rel_inc;
              if (rel_inc >= cfg_i.release_len) begin
                stall_flag_d = 1'b0;
                rel_cnt_d    = '0;
                attempt_d    = '0;
              end
            end else begin
              rel_cnt_d = '0;
            end
          end
        end
      end
      KIND_POLL: begin
        if (pending_q && (item_i.drive_state == DRIVE_STOPPED)) begin
          wait_cnt_d = wait_inc;
          if (wait_inc >= cfg_i.restart_wait_ticks) begin
            res.clear_faults      = cfg_i.option_flags[OPT_CLEAR_FAULT];
            pending_d             = 1'b0;
            wait_cnt_d            = '0;
            stall_flag_d          = 1'b0;
            cand_cnt_d            = '0;
            rel_cnt_d             = '0;
            res.run_request_valid = 1'b1;
            res.run_request       = item_i.target_present;
          end
        end
      end
      KIND_CLEAR: begin
        stall_flag_d = 1'b0;
        cand_cnt_d   = '0;
        rel_cnt_d    = '0;
        wait_cnt_d   = '0;
        attempt_d    = '0;
        pending_d    = 1'b0;
      end
      default: begin
        // An undefined tick kind leaves the state alone and reports status.
        stall_flag_d = stall_flag_q;
      end
    endcase

    res.stalled     = stall_flag_d;
    res.attempts    = attempt_d;
    res.event_total = event_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_flag_q <= 1'b0;
      cand_cnt_q   <= '0;
      rel_cnt_q    <= '0;
      wait_cnt_q   <= '0;
      attempt_q    <= '0;
      pending_q    <= 1'b0;
      event_q      <= '0;
    end else if (fire_i) begin
      stall_flag_q <= stall_flag_d;
      cand_cnt_q   <= cand_cnt_d;
      rel_cnt_q    <= rel_cnt_d;
      wait_cnt_q   <= wait_cnt_d;
      attempt_q    <= attempt_d;
      pending_q    <= pending_d;
      event_q      <= event_d;
    end
  end

  assign result_o = res;

  `SDR_ASSERT_SAME(a_stop_exclusive, clk_i, rst_ni, fire_i && res.restart_stop, !res.fault_stop)
  `SDR_ASSERT_SAME(a_exh_needs_fault, clk_i, rst_ni, fire_i && res.exhausted_fault, res.fault_stop)
  `SDR_ASSERT_NEXT(a_restart_pends, clk_i, rst_ni, fire_i && res.restart_stop, pending_q && stall_flag_q)
  `SDR_ASSERT_SAME(a_run_req_valid, clk_i, rst_ni, res.run_request, res.run_request_valid)

endmodule

>>> rtl/stall_detect_and_restart_core.sv
// Channel   Direction  Handshake                 Payload
// in        input      in_valid_i / in_stall_o   in_data_i  (sdr_in_t)
// out       output     out_valid_o / out_stall_i out_data_o (sdr_out_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// Each request waits in the input register and then moves to the result register, from which its
// result is offered; a stalled output holds it in either register. One request is taken every
// cycle while the output does not stall.
// The guard state is updated in the same edge that moves a request into the result register.
// Reset clears the guard state and loads the register defaults; no clearing pass is needed.
// A stalled output holds its result and backs up into the input register, then into in_stall_o.
`include "stall_detect_and_restart_core_macros.svh"

module stall_detect_and_restart_core
  import sdr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sdr_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sdr_out_t                out_data_o,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i
);

  sdr_cfg_t cfg;
  sdr_in_t  in_q;
  logic     in_valid_q;
  sdr_out_t out_q, res;
  logic     out_valid_q;
  logic     advance;

  // The input register drains whenever the result register is free or being emptied.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  sdr_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sdr_guard u_guard (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .cfg_i    (cfg),
    .item_i   (in_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SDR_ASSERT_NEXT(a_held_request, clk_i, rst_ni, in_valid_q && !advance, in_valid_q)
  `SDR_ASSERT_NEXT(a_advance_fills, clk_i, rst_ni, advance, out_valid_q)

endmodule
